/* rtl/core/amte_pkg.sv */
// Package: pipeline depth, calendar constants, reciprocal constants and month tables.
package amte_pkg;

  localparam int unsigned Stages = 15;

  localparam logic [21:0] EpochShift = 22'd719468;   // days 0000-03-01 .. 1970-01-01
  localparam logic [17:0] DaysPerEra = 18'd146097;   // days in 400 years
  localparam logic [16:0] SecsPerDay = 17'd86400;

  // Month codes, zero based (January is 0)
  localparam logic [3:0] MonFeb = 4'd1;
  localparam logic [3:0] MonMar = 4'd2;
  localparam logic [3:0] MonsPerYear = 4'd12;

  // Exact floor division by constant: q = (x * ceil(2^k / d)) >> k, with
  // k = width(x) + clog2(d), which is exact for every x of that width.
  localparam logic [31:0] Recip675    = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
  localparam logic [22:0] Recip146097 = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
  localparam logic [18:0] Recip1460   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] Recip36524  = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] Recip365    = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [11:0] Recip153    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [11:0] Recip12     = 12'(((64'd1 << 15) + 64'd11) / 64'd12);
  localparam logic [14:0] Recip100    = 15'(((64'd1 << 21) + 64'd99) / 64'd100);

  // Day of a March-based year on which each month starts: (153*mp + 2) / 5
  localparam logic [8:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  // Month lengths, January first, February in a common year
  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

endpackage

/* rtl/core/add_months_to_epoch_seconds.sv */
// Top level: epoch seconds plus calendar months with end-of-month clamp, 15-stage pipeline.
//
// Takes one word per clock while in_ready_o is high: a UTC timestamp in
// seconds since 1970-01-01 and a month count. The timestamp is split into a
// day number and second of day, converted to a proleptic Gregorian date, the
// months are added with carry into the year, the day is clamped to the
// length of the target month (leap February has 29 days, 4/100/400 rule)
// and the date goes back to epoch seconds with the time of day kept.
// Throughput is one word per cycle while the output is not stalled. No stage
// has more than one multiply on its path (divisions by constants are done
// as reciprocal multiplies, shifts or compares), which sets the stage depth.
// The output register is the last stage; when out_ready_i is low with a word
// waiting, the whole pipe holds and in_ready_o drops, nothing is lost or
// repeated.
module add_months_to_epoch_seconds (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [37:0] start_seconds_i,
  input  logic [9:0]  month_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [38:0] result_seconds_o
);

  // Pipe advance: the whole pipe moves unless the output word is held.
  logic                            adv;
  logic [amte_pkg::Stages-1:0]     vld_q;
  logic [amte_pkg::Stages-1:0]     vld_d;

  assign adv        = !vld_q[amte_pkg::Stages-1] || out_ready_i;
  assign in_ready_o = adv;
  assign vld_d      = {vld_q[amte_pkg::Stages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // ---- Stage 1: day number = (secs >> 7) / 675, since 86400 = 128 * 675
  logic [30:0] s0_x;
  logic [62:0] s0_prod;
  logic [21:0] s1_day_q;
  logic [30:0] s1_x_q;
  logic [6:0]  s1_lo_q;
  logic [9:0]  s1_cnt_q;

  assign s0_x    = start_seconds_i[37:7];
  assign s0_prod = 63'(s0_x) * 63'(amte_pkg::Recip675);

  // ---- Stage 2: second of day, shift day number to a March-0000 base
  logic [30:0] s1_rem;
  logic [21:0] s2_z_q;
  logic [16:0] s2_sod_q;
  logic [9:0]  s2_cnt_q;

  assign s1_rem = s1_x_q - 31'(31'(s1_day_q) * 31'd675);

  // ---- Stage 3: era = z / 146097
  logic [44:0] s2_prod;
  logic [4:0]  s3_era_q;
  logic [21:0] s3_z_q;
  logic [16:0] s3_sod_q;
  logic [9:0]  s3_cnt_q;

  assign s2_prod = 45'(s2_z_q) * 45'(amte_pkg::Recip146097);

  // ---- Stage 4: day of era
  logic [21:0] s3_doe;
  logic [17:0] s4_doe_q;
  logic [4:0]  s4_era_q;
  logic [16:0] s4_sod_q;
  logic [9:0]  s4_cnt_q;

  assign s3_doe = s3_z_q - 22'(22'(s3_era_q) * 22'(amte_pkg::DaysPerEra));

  // ---- Stage 5: leap corrections doe/1460, doe/36524, doe/146096
  logic [36:0] s4_prod_a;
  logic [36:0] s4_prod_b;
  logic [6:0]  s5_a_q;
  logic [2:0]  s5_b_q;
  logic        s5_c_q;
  logic [17:0] s5_doe_q;
  logic [4:0]  s5_era_q;
  logic [16:0] s5_sod_q;
  logic [9:0]  s5_cnt_q;

  assign s4_prod_a = 37'(s4_doe_q) * 37'(amte_pkg::Recip1460);
  assign s4_prod_b = 37'(s4_doe_q) * 37'(amte_pkg::Recip36524);

  // ---- Stage 6: year of era
  logic [17:0] s5_t;
  logic [36:0] s5_prod;
  logic [8:0]  s6_yoe_q;
  logic [17:0] s6_doe_q;
  logic [4:0]  s6_era_q;
  logic [16:0] s6_sod_q;
  logic [9:0]  s6_cnt_q;

  assign s5_t    = s5_doe_q + 18'(s5_b_q) - 18'(s5_a_q) - 18'(s5_c_q);
  assign s5_prod = 37'(s5_t) * 37'(amte_pkg::Recip365);

  // ---- Stage 7: day of (March-based) year; yoe/100 from compares
  logic [1:0]  s6_cent;
  logic [17:0] s6_doy;
  logic [8:0]  s7_doy_q;
  logic [8:0]  s7_yoe_q;
  logic [4:0]  s7_era_q;
  logic [16:0] s7_sod_q;
  logic [9:0]  s7_cnt_q;

  always_comb begin
    if (s6_yoe_q >= 9'd300) begin
      s6_cent = 2'd3;
    end else if (s6_yoe_q >= 9'd200) begin
      s6_cent = 2'd2;
    end else if (s6_yoe_q >= 9'd100) begin
      s6_cent = 2'd1;
    end else begin
      s6_cent = 2'd0;
    end
  end

  assign s6_doy = s6_doe_q - (18'(18'(s6_yoe_q) * 18'd365) + 18'(s6_yoe_q[8:2])
                  - 18'(s6_cent));

  // ---- Stage 8: March-based month mp = (5*doy + 2) / 153
  logic [10:0] s7_num;
  logic [22:0] s7_prod;
  logic [3:0]  s8_mp_q;
  logic [8:0]  s8_doy_q;
  logic [8:0]  s8_yoe_q;
  logic [4:0]  s8_era_q;
  logic [16:0] s8_sod_q;
  logic [9:0]  s8_cnt_q;

  assign s7_num  = 11'({s7_doy_q, 2'b00}) + 11'(s7_doy_q) + 11'd2;
  assign s7_prod = 23'(s7_num) * 23'(amte_pkg::Recip153);

  // ---- Stage 9: civil day, civil year, month total with the count added
  logic        s8_jan_feb;
  logic [3:0]  s8_mon0;
  logic [8:0]  s8_day;
  logic [13:0] s9_y_q;
  logic [10:0] s9_total_q;
  logic [4:0]  s9_d_q;
  logic [16:0] s9_sod_q;

  assign s8_jan_feb = (s8_mp_q >= 4'd10);
  assign s8_mon0    = s8_jan_feb ? s8_mp_q - 4'd10 : s8_mp_q + 4'd2;
  assign s8_day     = s8_doy_q - amte_pkg::MonthStart[s8_mp_q] + 9'd1;

  // ---- Stage 10: years carried = total / 12
  logic [22:0] s9_prod;
  logic [6:0]  s10_tq_q;
  logic [10:0] s10_total_q;
  logic [13:0] s10_y_q;
  logic [4:0]  s10_d_q;
  logic [16:0] s10_sod_q;

  assign s9_prod = 23'(s9_total_q) * 23'(amte_pkg::Recip12);

  // ---- Stage 11: target month and year
  logic [10:0] s10_mon_full;
  logic [3:0]  s11_mon_q;
  logic [13:0] s11_y2_q;
  logic [4:0]  s11_d_q;
  logic [16:0] s11_sod_q;

  assign s10_mon_full = s10_total_q - 11'(11'(s10_tq_q) * 11'(amte_pkg::MonsPerYear));

  // ---- Stage 12: year / 100 for the leap test and for the March-based year
  logic [13:0] s11_yb;
  logic [28:0] s11_prod_a;
  logic [28:0] s11_prod_b;
  logic [6:0]  s12_qa_q;
  logic [6:0]  s12_qb_q;
  logic [13:0] s12_y2_q;
  logic [13:0] s12_yb_q;
  logic [3:0]  s12_mon_q;
  logic [4:0]  s12_d_q;
  logic [16:0] s12_sod_q;

  assign s11_yb     = s11_y2_q - 14'(s11_mon_q < amte_pkg::MonMar);
  assign s11_prod_a = 29'(s11_y2_q) * 29'(amte_pkg::Recip100);
  assign s11_prod_b = 29'(s11_yb) * 29'(amte_pkg::Recip100);

  // ---- Stage 13: clamp the day, day of March-based year, era and year of era
  logic        s12_cent_year;
  logic        s12_leap;
  logic [4:0]  s12_lim;
  logic [4:0]  s12_dc;
  logic [3:0]  s12_mp2;
  logic [4:0]  s12_era2;
  logic [13:0] s12_yoe2;
  logic [8:0]  s13_doy_q;
  logic [8:0]  s13_yoe_q;
  logic [1:0]  s13_cq_q;
  logic [4:0]  s13_era_q;
  logic [16:0] s13_sod_q;

  assign s12_cent_year = (s12_y2_q == 14'(14'(s12_qa_q) * 14'd100));
  assign s12_leap      = (s12_y2_q[1:0] == 2'd0) && (!s12_cent_year || s12_qa_q[1:0] == 2'd0);
  assign s12_lim       = amte_pkg::MonthLen[s12_mon_q]
                         + 5'(s12_mon_q == amte_pkg::MonFeb && s12_leap);
  assign s12_dc        = (s12_d_q > s12_lim) ? s12_lim : s12_d_q;
  assign s12_mp2       = (s12_mon_q >= amte_pkg::MonMar) ? s12_mon_q - amte_pkg::MonMar
                                                         : s12_mon_q + 4'd10;
  assign s12_era2      = s12_qb_q[6:2];
  assign s12_yoe2      = s12_yb_q - 14'(14'(s12_era2) * 14'd400);

  // ---- Stage 14: day number since the epoch
  logic [17:0] s13_doe;
  logic [23:0] s13_days;
  logic [22:0] s14_days_q;
  logic [16:0] s14_sod_q;

  assign s13_doe  = 18'(18'(s13_yoe_q) * 18'd365) + 18'(s13_yoe_q[8:2])
                    - 18'(s13_cq_q) + 18'(s13_doy_q);
  assign s13_days = 24'(24'(s13_era_q) * 24'(amte_pkg::DaysPerEra)) + 24'(s13_doe)
                    - 24'(amte_pkg::EpochShift);

  // ---- Stage 15: back to seconds, output register
  logic [38:0] s15_res_q;

  // Payload registers, no reset; they move with the valid bits.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_day_q    <= s0_prod[62:41];
      s1_x_q      <= s0_x;
      s1_lo_q     <= start_seconds_i[6:0];
      s1_cnt_q    <= month_count_i;

      s2_z_q      <= s1_day_q + amte_pkg::EpochShift;
      s2_sod_q    <= {s1_rem[9:0], s1_lo_q};
      s2_cnt_q    <= s1_cnt_q;

      s3_era_q    <= s2_prod[44:40];
      s3_z_q      <= s2_z_q;
      s3_sod_q    <= s2_sod_q;
      s3_cnt_q    <= s2_cnt_q;

      s4_doe_q    <= s3_doe[17:0];
      s4_era_q    <= s3_era_q;
      s4_sod_q    <= s3_sod_q;
      s4_cnt_q    <= s3_cnt_q;

      s5_a_q      <= s4_prod_a[35:29];
      s5_b_q      <= s4_prod_b[36:34];
      s5_c_q      <= (s4_doe_q == 18'd146096);
      s5_doe_q    <= s4_doe_q;
      s5_era_q    <= s4_era_q;
      s5_sod_q    <= s4_sod_q;
      s5_cnt_q    <= s4_cnt_q;

      s6_yoe_q    <= s5_prod[35:27];
      s6_doe_q    <= s5_doe_q;
      s6_era_q    <= s5_era_q;
      s6_sod_q    <= s5_sod_q;
      s6_cnt_q    <= s5_cnt_q;

      s7_doy_q    <= s6_doy[8:0];
      s7_yoe_q    <= s6_yoe_q;
      s7_era_q    <= s6_era_q;
      s7_sod_q    <= s6_sod_q;
      s7_cnt_q    <= s6_cnt_q;

      s8_mp_q     <= s7_prod[22:19];
      s8_doy_q    <= s7_doy_q;
      s8_yoe_q    <= s7_yoe_q;
      s8_era_q    <= s7_era_q;
      s8_sod_q    <= s7_sod_q;
      s8_cnt_q    <= s7_cnt_q;

      s9_y_q      <= 14'(s8_yoe_q) + 14'(14'(s8_era_q) * 14'd400) + 14'(s8_jan_feb);
      s9_total_q  <= 11'(s8_mon0) + 11'(s8_cnt_q);
      s9_d_q      <= s8_day[4:0];
      s9_sod_q    <= s8_sod_q;

      s10_tq_q    <= s9_prod[21:15];
      s10_total_q <= s9_total_q;
      s10_y_q     <= s9_y_q;
      s10_d_q     <= s9_d_q;
      s10_sod_q   <= s9_sod_q;

      s11_mon_q   <= s10_mon_full[3:0];
      s11_y2_q    <= s10_y_q + 14'(s10_tq_q);
      s11_d_q     <= s10_d_q;
      s11_sod_q   <= s10_sod_q;

      s12_qa_q    <= s11_prod_a[27:21];
      s12_qb_q    <= s11_prod_b[27:21];
      s12_y2_q    <= s11_y2_q;
      s12_yb_q    <= s11_yb;
      s12_mon_q   <= s11_mon_q;
      s12_d_q     <= s11_d_q;
      s12_sod_q   <= s11_sod_q;

      s13_doy_q   <= amte_pkg::MonthStart[s12_mp2] + 9'(s12_dc) - 9'd1;
      s13_yoe_q   <= s12_yoe2[8:0];
      s13_cq_q    <= s12_qb_q[1:0];
      s13_era_q   <= s12_era2;
      s13_sod_q   <= s12_sod_q;

      s14_days_q  <= s13_days[22:0];
      s14_sod_q   <= s13_sod_q;

      s15_res_q   <= 39'(39'(s14_days_q) * 39'(amte_pkg::SecsPerDay)) + 39'(s14_sod_q);
    end
  end

  assign out_valid_o      = vld_q[amte_pkg::Stages-1];
  assign result_seconds_o = s15_res_q;

endmodule

/* rtl/core/amte_checker.sv */
// Checker: port-level assertions for the month adder, bound to the top level.
module amte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [38:0] result_seconds_o
);

  // Held output word stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_seconds_o))
    else $error("output word changed while stalled");

  // Input side only stalls because of a held output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

  // Taking the output word always frees the input side
  a_drain_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input not ready while output word is taken");

endmodule

bind add_months_to_epoch_seconds amte_checker u_amte_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .result_seconds_o (result_seconds_o)
);
